>>> rtl/c_style_token_lexer_unit_macros.svh
// assertion macros for the c-style token lexer
// used by the top level only, no other dependencies
`ifndef C_STYLE_TOKEN_LEXER_UNIT_MACROS_SVH
`define C_STYLE_TOKEN_LEXER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define CTL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CTL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ctl_pkg.sv
// shared types, codes and lexing functions of the c-style token lexer
// no dependencies; used by every rtl file of the block but the macro header
package ctl_pkg;

    // line counter width and width of the line field on the result channel
    localparam int LINE_BITS  = 16;
    localparam int LINE_OUT_W = 16;

    // result buffer in the back end: at most four beats per source byte
    localparam int SLOTS   = 4;
    localparam int SLOT_IW = $clog2(SLOTS);
    localparam int SLOT_CW = $clog2(SLOTS + 1);

    // work queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // control characters and the backslash
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_ESC = 8'h1B;
    localparam logic [7:0] CH_BSL = 8'h5C;

    // codes for the two-character operators
    localparam logic [8:0] PV_EQ_EQ    = 9'd256;
    localparam logic [8:0] PV_BANG_EQ  = 9'd257;
    localparam logic [8:0] PV_CARET_EQ = 9'd258;
    localparam logic [8:0] PV_LT_EQ    = 9'd259;
    localparam logic [8:0] PV_GT_EQ    = 9'd260;

    typedef logic [LINE_OUT_W-1:0] line_out_t;

    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2,
        KIND_EOI   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        TT_NONE   = 3'd0,
        TT_IDENT  = 3'd1,
        TT_NUMBER = 3'd2,
        TT_STRING = 3'd3,
        TT_CHAR   = 3'd4,
        TT_PUNCT  = 3'd5
    } ttype_t;

    typedef enum logic [2:0] {
        ERR_NONE          = 3'd0,
        ERR_UNEXPECTED    = 3'd1,
        ERR_UNTERM_CHAR   = 3'd2,
        ERR_UNTERM_STRING = 3'd3,
        ERR_BAD_ESCAPE    = 3'd4
    } err_t;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_NUMBER, M_STRING, M_STR_ESC,
        M_CHR_OPEN, M_CHR_ESC, M_CHR_CLOSE, M_DOT, M_DOTDOT,
        M_EQ, M_BANG, M_CARET, M_LT, M_GT
    } mode_t;

    typedef struct packed {
        kind_t      kind;
        ttype_t     token_type;
        logic [8:0] value;
        err_t       error_code;
    } result_t;

    // one queued unit of work: up to two bytes to lex, then an optional close
    typedef struct packed {
        logic       op0_v;
        logic [7:0] op0;
        logic       op1_v;
        logic [7:0] op1;
        logic       eoi;
        line_out_t  line;
    } work_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] clv;
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } step_t;

    typedef struct packed {
        mode_t   mode;
        logic    emit;
        result_t r;
    } idle_t;

    typedef struct packed {
        logic    emit;
        result_t r;
    } close_t;

    function automatic result_t mk_res(kind_t k, ttype_t t, logic [8:0] v, err_t e);
        result_t r;
        r.kind       = k;
        r.token_type = t;
        r.value      = v;
        r.error_code = e;
        return r;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == " ") || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic [7:0] escape_of(logic [7:0] c);
        logic [7:0] e;
        case (c)
            "a":     e = 8'h07;
            "b":     e = 8'h08;
            "f":     e = 8'h0C;
            "n":     e = CH_NL;
            "r":     e = CH_CR;
            "t":     e = CH_TAB;
            "v":     e = 8'h0B;
            "e":     e = CH_ESC;
            default: e = c;
        endcase
        return e;
    endfunction

    function automatic logic [8:0] single_of(mode_t m);
        logic [8:0] v;
        case (m)
            M_EQ:    v = {1'b0, 8'("=")};
            M_BANG:  v = {1'b0, 8'("!")};
            M_CARET: v = {1'b0, 8'("^")};
            M_LT:    v = {1'b0, 8'("<")};
            default: v = {1'b0, 8'(">")};
        endcase
        return v;
    endfunction

    function automatic logic [8:0] pair_of(mode_t m);
        logic [8:0] v;
        case (m)
            M_EQ:    v = PV_EQ_EQ;
            M_BANG:  v = PV_BANG_EQ;
            M_CARET: v = PV_CARET_EQ;
            M_LT:    v = PV_LT_EQ;
            default: v = PV_GT_EQ;
        endcase
        return v;
    endfunction

    // byte seen with no token open
    function automatic idle_t idle_f(logic [7:0] c);
        idle_t s;
        s.mode = M_IDLE;
        s.emit = 1'b0;
        s.r    = mk_res(KIND_CHAR, TT_NONE, 9'd0, ERR_NONE);
        if (is_space(c)) begin
            s.emit = 1'b0;
        end
        else if (is_digit(c)) begin
            s.emit = 1'b1;
            s.r    = mk_res(KIND_CHAR, TT_NUMBER, {1'b0, c}, ERR_NONE);
            s.mode = M_NUMBER;
        end
        else if (is_alpha(c) || (c == "_")) begin
            s.emit = 1'b1;
            s.r    = mk_res(KIND_CHAR, TT_IDENT, {1'b0, c}, ERR_NONE);
            s.mode = M_IDENT;
        end
        else begin
            case (c) inside
                "\"": s.mode = M_STRING;
                "'":  s.mode = M_CHR_OPEN;
                "=":  s.mode = M_EQ;
                "!":  s.mode = M_BANG;
                "^":  s.mode = M_CARET;
                "<":  s.mode = M_LT;
                ">":  s.mode = M_GT;
                ".":  s.mode = M_DOT;
                "(", ")", ",", ";", "[", "]", "{", "}", "?", ":", "~":
                begin
                    s.emit = 1'b1;
                    s.r    = mk_res(KIND_DONE, TT_PUNCT, {1'b0, c}, ERR_NONE);
                end
                default:
                begin
                    s.emit = 1'b1;
                    s.r    = mk_res(KIND_ERROR, TT_NONE, {1'b0, c}, ERR_UNEXPECTED);
                end
            endcase
        end
        return s;
    endfunction

    // one byte through the lexer: at most two result beats
    function automatic step_t step_f(mode_t m, logic [7:0] clv, logic [7:0] c);
        step_t s;
        idle_t id;
        logic  fall;
        s.mode = m;
        s.clv  = clv;
        s.n    = 2'd0;
        s.r0   = mk_res(KIND_CHAR, TT_NONE, 9'd0, ERR_NONE);
        s.r1   = mk_res(KIND_CHAR, TT_NONE, 9'd0, ERR_NONE);
        fall   = 1'b0;
        case (m)
            M_IDENT:
            begin
                s.n = 2'd1;
                if (is_alpha(c) || is_digit(c) || (c == "_") || (c == "$")) begin
                    s.r0 = mk_res(KIND_CHAR, TT_IDENT, {1'b0, c}, ERR_NONE);
                end
                else begin
                    s.r0 = mk_res(KIND_DONE, TT_IDENT, 9'd0, ERR_NONE);
                    fall = 1'b1;
                end
            end
            M_NUMBER:
            begin
                s.n = 2'd1;
                if (is_alpha(c) || is_digit(c) || (c == ".")) begin
                    s.r0 = mk_res(KIND_CHAR, TT_NUMBER, {1'b0, c}, ERR_NONE);
                end
                else begin
                    s.r0 = mk_res(KIND_DONE, TT_NUMBER, 9'd0, ERR_NONE);
                    fall = 1'b1;
                end
            end
            M_STRING:
            begin
                if (c == "\"") begin
                    s.n    = 2'd1;
                    s.r0   = mk_res(KIND_DONE, TT_STRING, 9'd0, ERR_NONE);
                    s.mode = M_IDLE;
                end
                else if (c == CH_BSL) begin
                    s.mode = M_STR_ESC;
                end
                else begin
                    s.n  = 2'd1;
                    s.r0 = mk_res(KIND_CHAR, TT_STRING, {1'b0, c}, ERR_NONE);
                end
            end
            M_STR_ESC:
            begin
                s.n    = 2'd1;
                s.r0   = mk_res(KIND_CHAR, TT_STRING, {1'b0, escape_of(c)}, ERR_NONE);
                s.mode = M_STRING;
            end
            M_CHR_OPEN:
            begin
                if (c == CH_BSL) begin
                    s.mode = M_CHR_ESC;
                end
                else begin
                    s.clv  = c;
                    s.mode = M_CHR_CLOSE;
                end
            end
            M_CHR_ESC:
            begin
                s.clv  = escape_of(c);
                s.mode = M_CHR_CLOSE;
            end
            M_CHR_CLOSE:
            begin
                s.n = 2'd1;
                if (c == "'") begin
                    s.r0 = mk_res(KIND_DONE, TT_CHAR, {1'b0, clv}, ERR_NONE);
                end
                else begin
                    s.r0 = mk_res(KIND_ERROR, TT_NONE, 9'd0, ERR_UNTERM_CHAR);
                end
                s.mode = M_IDLE;
            end
            M_DOT:
            begin
                if (is_digit(c)) begin
                    s.n    = 2'd2;
                    s.r0   = mk_res(KIND_CHAR, TT_NUMBER, {1'b0, 8'(".")}, ERR_NONE);
                    s.r1   = mk_res(KIND_CHAR, TT_NUMBER, {1'b0, c}, ERR_NONE);
                    s.mode = M_NUMBER;
                end
                else if (c == ".") begin
                    s.n    = 2'd2;
                    s.r0   = mk_res(KIND_CHAR, TT_IDENT, {1'b0, 8'(".")}, ERR_NONE);
                    s.r1   = mk_res(KIND_CHAR, TT_IDENT, {1'b0, 8'(".")}, ERR_NONE);
                    s.mode = M_DOTDOT;
                end
                else begin
                    s.n  = 2'd1;
                    s.r0 = mk_res(KIND_DONE, TT_PUNCT, {1'b0, 8'(".")}, ERR_NONE);
                    fall = 1'b1;
                end
            end
            M_DOTDOT:
            begin
                s.n    = 2'd2;
                s.r0   = mk_res(KIND_CHAR, TT_IDENT, {1'b0, c}, ERR_NONE);
                s.r1   = mk_res(KIND_DONE, TT_IDENT, 9'd0, ERR_NONE);
                s.mode = M_IDLE;
            end
            M_EQ, M_BANG, M_CARET, M_LT, M_GT:
            begin
                s.n = 2'd1;
                if (c == "=") begin
                    s.r0   = mk_res(KIND_DONE, TT_PUNCT, pair_of(m), ERR_NONE);
                    s.mode = M_IDLE;
                end
                else begin
                    s.r0 = mk_res(KIND_DONE, TT_PUNCT, single_of(m), ERR_NONE);
                    fall = 1'b1;
                end
            end
            default:
            begin
                fall = 1'b1;
            end
        endcase
        // token ended: the same byte is looked at again with nothing open
        if (fall) begin
            id     = idle_f(c);
            s.mode = id.mode;
            if (id.emit) begin
                if (s.n == 2'd0) begin
                    s.r0 = id.r;
                end
                else begin
                    s.r1 = id.r;
                end
            end
            s.n = s.n + {1'b0, id.emit};
        end
        return s;
    endfunction

    // end of input: finish or fault whatever token is open
    function automatic close_t close_f(mode_t m);
        close_t s;
        s.emit = 1'b1;
        s.r    = mk_res(KIND_CHAR, TT_NONE, 9'd0, ERR_NONE);
        case (m) inside
            M_IDENT, M_DOTDOT:
                s.r = mk_res(KIND_DONE, TT_IDENT, 9'd0, ERR_NONE);
            M_NUMBER:
                s.r = mk_res(KIND_DONE, TT_NUMBER, 9'd0, ERR_NONE);
            M_STRING:
                s.r = mk_res(KIND_ERROR, TT_NONE, 9'd0, ERR_UNTERM_STRING);
            M_STR_ESC, M_CHR_ESC:
                s.r = mk_res(KIND_ERROR, TT_NONE, 9'd0, ERR_BAD_ESCAPE);
            M_CHR_OPEN, M_CHR_CLOSE:
                s.r = mk_res(KIND_ERROR, TT_NONE, 9'd0, ERR_UNTERM_CHAR);
            M_DOT:
                s.r = mk_res(KIND_DONE, TT_PUNCT, {1'b0, 8'(".")}, ERR_NONE);
            M_EQ, M_BANG, M_CARET, M_LT, M_GT:
                s.r = mk_res(KIND_DONE, TT_PUNCT, single_of(m), ERR_NONE);
            default:
                s.emit = 1'b0;
        endcase
        return s;
    endfunction

endpackage

>>> rtl/ctl_ifs.sv
// valid/ready channel interfaces of the c-style token lexer
// source byte channel and token result channel; line type from ctl_pkg
interface ctl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_input;

    modport source (output valid, output ch, output end_of_input, input ready);
    modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

interface ctl_token_if;
    logic                valid;
    logic                ready;
    logic [1:0]          kind;
    logic [2:0]          token_type;
    logic [8:0]          value;
    logic [2:0]          error_code;
    ctl_pkg::line_out_t  line;
    logic                last;

    modport source (output valid, output kind, output token_type, output value,
                    output error_code, output line, output last, input ready);
    modport sink   (input valid, input kind, input token_type, input value,
                    input error_code, input line, input last, output ready);
endinterface

>>> rtl/c_style_token_lexer_unit.sv
// top level of the c-style token lexer: front end, work queue, back end
// depends on ctl_pkg, ctl_ifs, ctl_front, ctl_queue, ctl_back and the macro header
//
//  channel   role    beat contents
//  bytes     sink    ch, end_of_input
//  tokens    source  kind, token_type, value, error_code, line, last
//
// a source byte is taken every cycle while the two-entry work queue has room
// each byte gives zero to four token beats, one per cycle while tokens.ready is high, from the result buffer
// the back end loads the next queued byte in the cycle its last beat leaves
// reset: nothing open, no held backslash, line count 1, queue and buffer empty
// a stall on tokens fills the queue, after which bytes.ready drops
`include "c_style_token_lexer_unit_macros.svh"

module c_style_token_lexer_unit (
    input  logic          clk,
    input  logic          rst_n,
    ctl_byte_if.sink      bytes,
    ctl_token_if.source   tokens
);

    logic              q_full;
    logic              push;
    ctl_pkg::work_t    push_item;
    logic              pop;
    logic              q_valid;
    ctl_pkg::work_t    q_item;

    // splice and line count
    ctl_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .bytes  (bytes),
        .q_full (q_full),
        .push   (push),
        .item   (push_item)
    );

    // decoupling queue
    ctl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    // lexer and result drain
    ctl_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .pop     (pop),
        .tokens  (tokens)
    );

    // a beat that is not the last of its byte is followed by another
    `CTL_ASSERT_NEXT(a_more_after_not_last, clk, rst_n, tokens.valid && tokens.ready && !tokens.last, tokens.valid, "result beats of one byte broken off")
    // the back end never loads while earlier beats still wait
    `CTL_ASSERT_NOW(a_no_load_over_pending, clk, rst_n, pop, !tokens.valid || (tokens.ready && tokens.last), "result buffer overwritten")
    // end of input always reaches the back end
    `CTL_ASSERT_NOW(a_eoi_pushed, clk, rst_n, bytes.valid && bytes.ready && bytes.end_of_input, push, "end of input lost in front end")

endmodule

>>> rtl/ctl_front.sv
// front end: accepts source bytes, splices backslash-newline, counts lines
// depends on ctl_pkg and ctl_byte_if
module ctl_front (
    input  logic              clk,
    input  logic              rst_n,
    ctl_byte_if.sink          bytes,
    input  logic              q_full,
    output logic              push,
    output ctl_pkg::work_t    item
);

    logic                           pend_reg;
    logic                           pend_next;
    logic [ctl_pkg::LINE_BITS-1:0]  line_reg;
    logic [ctl_pkg::LINE_BITS-1:0]  line_next;
    logic [ctl_pkg::LINE_BITS+ctl_pkg::LINE_OUT_W-1:0] line_ext;
    logic                           acc;
    logic                           is_nl;

    assign bytes.ready = !q_full;
    assign acc         = bytes.valid && bytes.ready;
    assign is_nl       = !bytes.end_of_input && (bytes.ch == ctl_pkg::CH_NL);

    // line count after this beat, cut or padded to the result width
    always_comb
    begin
        line_next = is_nl ? (line_reg + ctl_pkg::LINE_BITS'(1)) : line_reg;
        line_ext  = {{ctl_pkg::LINE_OUT_W{1'b0}}, line_next};
    end

    // splice and pick the bytes to hand to the lexer
    always_comb
    begin
        item.op0_v = 1'b0;
        item.op0   = ctl_pkg::CH_BSL;
        item.op1_v = 1'b0;
        item.op1   = bytes.ch;
        item.eoi   = bytes.end_of_input;
        item.line  = line_ext[ctl_pkg::LINE_OUT_W-1:0];
        pend_next  = pend_reg;
        if (bytes.end_of_input) begin
            item.op0_v = pend_reg;
            pend_next  = 1'b0;
        end
        else if (pend_reg) begin
            if (bytes.ch == ctl_pkg::CH_NL) begin
                pend_next = 1'b0;
            end
            else begin
                item.op0_v = 1'b1;
                if (bytes.ch == ctl_pkg::CH_BSL) begin
                    pend_next = 1'b1;
                end
                else begin
                    item.op1_v = 1'b1;
                    pend_next  = 1'b0;
                end
            end
        end
        else if (bytes.ch == ctl_pkg::CH_BSL) begin
            pend_next = 1'b1;
        end
        else begin
            item.op0_v = 1'b1;
            item.op0   = bytes.ch;
        end
    end

    assign push = acc && (item.op0_v || item.eoi);

    // splice flag and line counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pend_reg <= 1'b0;
            line_reg <= ctl_pkg::LINE_BITS'(1);
        end
        else if (acc) begin
            pend_reg <= pend_next;
            line_reg <= line_next;
        end
    end

endmodule

>>> rtl/ctl_queue.sv
// short work queue between the front end and the lexing back end
// depends on ctl_pkg
module ctl_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ctl_pkg::work_t    push_item,
    output logic              full,
    input  logic              pop,
    output logic              q_valid,
    output ctl_pkg::work_t    q_item
);

    ctl_pkg::work_t                entry_reg [ctl_pkg::Q_DEPTH];
    logic [ctl_pkg::Q_PTR_W-1:0]   wptr_reg;
    logic [ctl_pkg::Q_PTR_W-1:0]   wptr_next;
    logic [ctl_pkg::Q_PTR_W-1:0]   rptr_reg;
    logic [ctl_pkg::Q_PTR_W-1:0]   rptr_next;
    logic [ctl_pkg::Q_CNT_W-1:0]   cnt_reg;
    logic [ctl_pkg::Q_CNT_W-1:0]   cnt_next;
    logic                          do_push;
    logic                          do_pop;

    assign full    = (cnt_reg == ctl_pkg::Q_CNT_W'(ctl_pkg::Q_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_item  = entry_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    // pointer wrap and occupancy
    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        if (do_push) begin
            wptr_next = (wptr_reg == ctl_pkg::Q_PTR_W'(ctl_pkg::Q_DEPTH - 1)) ?
                        '0 : wptr_reg + ctl_pkg::Q_PTR_W'(1);
        end
        if (do_pop) begin
            rptr_next = (rptr_reg == ctl_pkg::Q_PTR_W'(ctl_pkg::Q_DEPTH - 1)) ?
                        '0 : rptr_reg + ctl_pkg::Q_PTR_W'(1);
        end
        cnt_next = cnt_reg + ctl_pkg::Q_CNT_W'(do_push) - ctl_pkg::Q_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entry_reg[wptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/ctl_back.sv
// back end: runs the lexer over one queued work unit and drains its beats
// depends on ctl_pkg and ctl_token_if
module ctl_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  ctl_pkg::work_t    q_item,
    output logic              pop,
    ctl_token_if.source       tokens
);

    ctl_pkg::mode_t                mode_reg;
    logic [7:0]                    clv_reg;
    ctl_pkg::result_t              slot_reg [ctl_pkg::SLOTS];
    ctl_pkg::result_t              slot_next [ctl_pkg::SLOTS];
    logic [ctl_pkg::SLOT_CW-1:0]   cnt_reg;
    logic [ctl_pkg::SLOT_CW-1:0]   cnt_next;
    logic [ctl_pkg::SLOT_CW-1:0]   new_cnt;
    logic [ctl_pkg::SLOT_IW-1:0]   idx_reg;
    logic [ctl_pkg::SLOT_IW-1:0]   idx_next;
    ctl_pkg::line_out_t            line_reg;
    ctl_pkg::step_t                s1;
    ctl_pkg::step_t                s2;
    ctl_pkg::close_t               cl;
    ctl_pkg::mode_t                mode_fin;
    ctl_pkg::result_t              cand [6];
    logic [5:0]                    cand_v;
    ctl_pkg::result_t              cur;
    logic                          fire;
    logic                          is_last;
    logic                          free;

    // lex the work unit: first byte, second byte, then the close at end of input
    always_comb
    begin
        if (q_item.op0_v) begin
            s1 = ctl_pkg::step_f(mode_reg, clv_reg, q_item.op0);
        end
        else begin
            s1      = '0;
            s1.mode = mode_reg;
            s1.clv  = clv_reg;
        end
        if (q_item.op1_v) begin
            s2 = ctl_pkg::step_f(s1.mode, s1.clv, q_item.op1);
        end
        else begin
            s2 = s1;
            s2.n = 2'd0;
        end
        cl       = ctl_pkg::close_f(s2.mode);
        mode_fin = q_item.eoi ? ctl_pkg::M_IDLE : s2.mode;
    end

    // gather the beats in order into the result buffer
    always_comb
    begin
        cand[0]   = s1.r0;
        cand[1]   = s1.r1;
        cand[2]   = s2.r0;
        cand[3]   = s2.r1;
        cand[4]   = cl.r;
        cand[5]   = ctl_pkg::mk_res(ctl_pkg::KIND_EOI, ctl_pkg::TT_NONE, 9'd0,
                                    ctl_pkg::ERR_NONE);
        cand_v[0] = q_item.op0_v && (s1.n != 2'd0);
        cand_v[1] = q_item.op0_v && (s1.n == 2'd2);
        cand_v[2] = q_item.op1_v && (s2.n != 2'd0);
        cand_v[3] = q_item.op1_v && (s2.n == 2'd2);
        cand_v[4] = q_item.eoi && cl.emit;
        cand_v[5] = q_item.eoi;
        for (int i = 0; i < ctl_pkg::SLOTS; i++) begin
            slot_next[i] = slot_reg[i];
        end
        new_cnt = '0;
        for (int i = 0; i < 6; i++) begin
            if (cand_v[i]) begin
                slot_next[new_cnt[ctl_pkg::SLOT_IW-1:0]] = cand[i];
                new_cnt = new_cnt + ctl_pkg::SLOT_CW'(1);
            end
        end
    end

    // drain control
    assign cur     = slot_reg[idx_reg];
    assign fire    = tokens.valid && tokens.ready;
    assign is_last = ({1'b0, idx_reg} == (cnt_reg - ctl_pkg::SLOT_CW'(1)));
    assign free    = (cnt_reg == '0) || (fire && is_last);
    assign pop     = q_valid && free;

    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (pop) begin
            cnt_next = new_cnt;
            idx_next = '0;
        end
        else if (fire) begin
            if (is_last) begin
                cnt_next = '0;
                idx_next = '0;
            end
            else begin
                idx_next = idx_reg + ctl_pkg::SLOT_IW'(1);
            end
        end
    end

    // lexer state and buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= ctl_pkg::M_IDLE;
            clv_reg  <= 8'd0;
            cnt_reg  <= '0;
            idx_reg  <= '0;
        end
        else begin
            if (pop) begin
                mode_reg <= mode_fin;
                clv_reg  <= s2.clv;
            end
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    // result buffer payload
    always_ff @(posedge clk)
    begin
        if (pop) begin
            for (int i = 0; i < ctl_pkg::SLOTS; i++) begin
                slot_reg[i] <= slot_next[i];
            end
            line_reg <= q_item.line;
        end
    end

    assign tokens.valid      = (cnt_reg != '0);
    assign tokens.kind       = cur.kind;
    assign tokens.token_type = cur.token_type;
    assign tokens.value      = cur.value;
    assign tokens.error_code = cur.error_code;
    assign tokens.line       = line_reg;
    assign tokens.last       = is_last;

endmodule
